[src/weighted_history_pollution_predictor_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the weighted history pollution predictor
// Shared concurrent-assertion forms, clocked on the rising edge and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_HISTORY_POLLUTION_PREDICTOR_ASSERT_SVH
`define WEIGHTED_HISTORY_POLLUTION_PREDICTOR_ASSERT_SVH

// same-cycle implication
`define WHPP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define WHPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/whpp_pkg.sv]
// ----------------------------------------------------------------------------
// whpp_pkg
// Types and constants shared by the predictor controller, datapath and top.
// ----------------------------------------------------------------------------
package whpp_pkg;

   localparam int NPOLL     = 4;
   localparam int LVL_W     = 20;
   localparam int PRED_W    = 21;
   localparam int FW_W      = 13;
   localparam int FH_W      = 5;
   localparam int NUMF_W    = 17;
   localparam int CSR_IDX_W = 2;
   localparam int DEN_SCALE = 100000;

   localparam logic [PRED_W-1:0] PRED_MAX = 21'h1FFFFF;

   localparam logic [15:0]     WIND_FLOOR_SPEED = 16'd3500;
   localparam logic [FW_W-1:0] FW_BASE          = 13'd6000;
   localparam logic [FW_W-1:0] FW_MIN           = 13'd2500;
   localparam logic [13:0]     HUM_THRESH       = 14'd7000;
   localparam logic [FH_W-1:0] FH_HIGH          = 5'd21;
   localparam logic [FH_W-1:0] FH_NOM           = 5'd20;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_CO2  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_SO2  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_NO2  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PM25 = 2'd3;

   localparam logic [LVL_W-1:0] LIMIT_CO2_RST  = 20'd100000;
   localparam logic [LVL_W-1:0] LIMIT_SO2_RST  = 20'd2000;
   localparam logic [LVL_W-1:0] LIMIT_NO2_RST  = 20'd4000;
   localparam logic [LVL_W-1:0] LIMIT_PM25_RST = 20'd2500;

   typedef struct packed {
      logic [2:0]       zone;
      logic [LVL_W-1:0] co2_level;
      logic [LVL_W-1:0] so2_level;
      logic [LVL_W-1:0] no2_level;
      logic [LVL_W-1:0] pm25_level;
      logic [15:0]      wind_speed;
      logic [13:0]      humidity;
   } req_type;

   typedef struct packed {
      logic [2:0]        zone_out;
      logic [PRED_W-1:0] pred_co2;
      logic [PRED_W-1:0] pred_so2;
      logic [PRED_W-1:0] pred_no2;
      logic [PRED_W-1:0] pred_pm25;
      logic [2:0]        now_over_count;
      logic [2:0]        pred_over_count;
      logic [3:0]        action_mask;
      logic [4:0]        samples_held;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_READ,
      ST_DRAIN,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic read;
      logic scale;
      logic divide;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rd_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

[src/whpp_ctrl.sv]
// ----------------------------------------------------------------------------
// whpp_ctrl
// Sequencer: append, history walk, scaling, long division, result hand-off.
// ----------------------------------------------------------------------------
`include "weighted_history_pollution_predictor_assert.svh"

module whpp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  whpp_pkg::status_type status,
   output whpp_pkg::cmd_type    cmd
);

   whpp_pkg::state_type state_ff;
   whpp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= whpp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         whpp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = whpp_pkg::ST_APPEND;
            end
         end
         whpp_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = whpp_pkg::ST_READ;
         end
         whpp_pkg::ST_READ: begin
            cmd.read = 1'b1;
            if (status.rd_last) begin
               state_in = whpp_pkg::ST_DRAIN;
            end
         end
         whpp_pkg::ST_DRAIN: begin
            state_in = whpp_pkg::ST_SCALE;
         end
         whpp_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = whpp_pkg::ST_DIVIDE;
         end
         whpp_pkg::ST_DIVIDE: begin
            cmd.divide = 1'b1;
            if (status.div_last) begin
               state_in = whpp_pkg::ST_FINISH;
            end
         end
         whpp_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
            if (status.out_free) begin
               state_in = whpp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = whpp_pkg::ST_IDLE;
         end
      endcase
   end

   `WHPP_ASSERT_NEXT(a_accept_to_append, clock, reset, req_valid && req_ready, state_ff == whpp_pkg::ST_APPEND)
   `WHPP_ASSERT_NEXT(a_scale_to_divide, clock, reset, state_ff == whpp_pkg::ST_SCALE, state_ff == whpp_pkg::ST_DIVIDE)
   `WHPP_ASSERT_NEXT(a_finish_to_idle, clock, reset, cmd.finish, state_ff == whpp_pkg::ST_IDLE)

endmodule

[src/whpp_dp.sv]
// ----------------------------------------------------------------------------
// whpp_dp
// History rings, weighted accumulators, scaler, dividers and result register.
// ----------------------------------------------------------------------------
`include "weighted_history_pollution_predictor_assert.svh"

module whpp_dp #(
   parameter int ZONES       = 8,
   parameter int HISTORY_LEN = 30
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  whpp_pkg::cmd_type                      cmd,
   output whpp_pkg::status_type                   status,
   input  whpp_pkg::req_type                      req_data,
   input  logic                                   csr_write,
   input  logic [whpp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [whpp_pkg::LVL_W-1:0]             csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output whpp_pkg::rsp_type                      rsp_data
);

   localparam int ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int SW    = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int CW    = $clog2(HISTORY_LEN + 1);
   localparam int SLW   = ((SW > CW) ? SW : CW) + 1;
   localparam int WMAX  = HISTORY_LEN * (HISTORY_LEN + 1) / 2;
   localparam int WW    = $clog2(WMAX + 1);
   localparam int AW    = whpp_pkg::LVL_W + WW;
   localparam int DEPTH = ZONES * HISTORY_LEN;
   localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = $clog2(WMAX * whpp_pkg::DEN_SCALE + 1);
   localparam int NW    = AW + whpp_pkg::NUMF_W;
   localparam int QCW   = $clog2(NW);
   localparam int NP    = whpp_pkg::NPOLL;
   localparam int LW    = whpp_pkg::LVL_W;
   localparam int FW_W_L = whpp_pkg::FW_W;

   function automatic logic [2:0] zone_wrap(input logic [2:0] z);
      int zi;
      zi = int'(z);
      for (int i = 0; i < 8; i++) begin
         if (zi >= ZONES) begin
            zi = zi - ZONES;
         end
      end
      return 3'(zi);
   endfunction

   // captured sample
   logic [2:0]                   zone_ff;
   logic [LW-1:0]                lvl_ff [NP];
   logic [whpp_pkg::NUMF_W-1:0]  numf_ff;

   // per-zone ring control
   logic [CW-1:0]  cnt_ff [ZONES];
   logic [SW-1:0]  old_ff [ZONES];

   // walk state
   logic [CW-1:0]  n_ff;
   logic [CW-1:0]  k_ff;
   logic [SW-1:0]  rd_slot_ff;
   logic           rd_v_ff;
   logic [CW-1:0]  rd_w_ff;
   logic [LW-1:0]  rdata_ff [NP];
   logic [AW-1:0]  acc_ff [NP];
   logic [WW-1:0]  wsum_ff;

   // divider
   logic [NW-1:0]  quot_ff [NP];
   logic [DW-1:0]  rem_ff [NP];
   logic [DW-1:0]  den_ff;
   logic [QCW-1:0] qcnt_ff;

   logic [LW-1:0]  limit_ff [NP];
   logic           rsp_valid_ff;
   whpp_pkg::rsp_type rsp_ff;

   logic [LW-1:0]  lvl_in [NP];
   logic [ZW-1:0]  zidx;
   logic [CW-1:0]  cur_n;
   logic [SW-1:0]  cur_o;
   logic           full;
   logic [SLW-1:0] slot_sum;
   logic [SW-1:0]  wr_slot;
   logic [SW-1:0]  new_o;
   logic [MW-1:0]  zbase;
   logic [MW-1:0]  mem_addr;
   logic [FW_W_L-1:0] fwn;
   logic [whpp_pkg::FH_W-1:0] fhn;

   assign lvl_in[0] = req_data.co2_level;
   assign lvl_in[1] = req_data.so2_level;
   assign lvl_in[2] = req_data.no2_level;
   assign lvl_in[3] = req_data.pm25_level;

   // scale numerators: wind has a floor, humidity adds five percent
   always_comb begin
      if (req_data.wind_speed >= whpp_pkg::WIND_FLOOR_SPEED) begin
         fwn = whpp_pkg::FW_MIN;
      end else begin
         fwn = whpp_pkg::FW_BASE - req_data.wind_speed[FW_W_L-1:0];
      end
      fhn = (req_data.humidity > whpp_pkg::HUM_THRESH) ? whpp_pkg::FH_HIGH
                                                       : whpp_pkg::FH_NOM;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         zone_ff <= zone_wrap(req_data.zone);
         numf_ff <= whpp_pkg::NUMF_W'(fwn) * whpp_pkg::NUMF_W'(fhn);
         for (int p = 0; p < NP; p++) begin
            lvl_ff[p] <= lvl_in[p];
         end
      end
   end

   // ring append: write behind the newest entry, or overwrite the oldest
   always_comb begin
      zidx     = ZW'(zone_ff);
      cur_n    = cnt_ff[zidx];
      cur_o    = old_ff[zidx];
      full     = (cur_n == CW'(HISTORY_LEN));
      slot_sum = SLW'(cur_o) + SLW'(cur_n);
      if (slot_sum >= SLW'(HISTORY_LEN)) begin
         slot_sum = slot_sum - SLW'(HISTORY_LEN);
      end
      wr_slot = full ? cur_o : slot_sum[SW-1:0];
      if (full) begin
         new_o = (cur_o == SW'(HISTORY_LEN - 1)) ? '0 : cur_o + 1'b1;
      end else begin
         new_o = cur_o;
      end
      zbase    = MW'(int'(zidx) * HISTORY_LEN);
      mem_addr = zbase + MW'(cmd.append ? wr_slot : rd_slot_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            cnt_ff[z] <= '0;
            old_ff[z] <= '0;
         end
      end else if (cmd.append) begin
         cnt_ff[zidx] <= full ? cur_n : cur_n + 1'b1;
         old_ff[zidx] <= new_o;
      end
   end

   for (genvar gp = 0; gp < NP; gp++) begin : g_hist
      logic [LW-1:0] mem [DEPTH];
      always_ff @(posedge clock) begin
         if (cmd.append) begin
            mem[mem_addr] <= lvl_ff[gp];
         end
      end
      always_ff @(posedge clock) begin
         rdata_ff[gp] <= mem[mem_addr];
      end
   end

   // history walk, oldest first, weight k+1
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         n_ff       <= full ? cur_n : cur_n + 1'b1;
         k_ff       <= '0;
         rd_slot_ff <= new_o;
      end else if (cmd.read) begin
         k_ff       <= k_ff + 1'b1;
         rd_slot_ff <= (rd_slot_ff == SW'(HISTORY_LEN - 1)) ? '0 : rd_slot_ff + 1'b1;
      end
      rd_w_ff <= k_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         wsum_ff <= '0;
         for (int p = 0; p < NP; p++) begin
            acc_ff[p] <= '0;
         end
      end else if (rd_v_ff) begin
         wsum_ff <= wsum_ff + WW'(rd_w_ff);
         for (int p = 0; p < NP; p++) begin
            acc_ff[p] <= acc_ff[p] + AW'(rd_w_ff) * AW'(rdata_ff[p]);
         end
      end
   end

   // scale, then restoring division one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         den_ff  <= DW'(wsum_ff * whpp_pkg::DEN_SCALE);
         qcnt_ff <= '0;
         for (int p = 0; p < NP; p++) begin
            quot_ff[p] <= NW'(acc_ff[p]) * NW'(numf_ff);
            rem_ff[p]  <= '0;
         end
      end else if (cmd.divide) begin
         qcnt_ff <= qcnt_ff + 1'b1;
         for (int p = 0; p < NP; p++) begin
            if ({rem_ff[p], quot_ff[p][NW-1]} >= {1'b0, den_ff}) begin
               rem_ff[p] <= DW'({rem_ff[p], quot_ff[p][NW-1]} - {1'b0, den_ff});
               quot_ff[p] <= {quot_ff[p][NW-2:0], 1'b1};
            end else begin
               rem_ff[p] <= {rem_ff[p][DW-2:0], quot_ff[p][NW-1]};
               quot_ff[p] <= {quot_ff[p][NW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff[0] <= whpp_pkg::LIMIT_CO2_RST;
         limit_ff[1] <= whpp_pkg::LIMIT_SO2_RST;
         limit_ff[2] <= whpp_pkg::LIMIT_NO2_RST;
         limit_ff[3] <= whpp_pkg::LIMIT_PM25_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            whpp_pkg::CSR_LIMIT_CO2:  limit_ff[0] <= csr_data;
            whpp_pkg::CSR_LIMIT_SO2:  limit_ff[1] <= csr_data;
            whpp_pkg::CSR_LIMIT_NO2:  limit_ff[2] <= csr_data;
            whpp_pkg::CSR_LIMIT_PM25: limit_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // result assembly
   logic [whpp_pkg::PRED_W-1:0] pred [NP];
   logic [NP-1:0] now_over;
   logic [NP-1:0] pred_over;
   whpp_pkg::rsp_type rsp_in;

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         pred[p] = (quot_ff[p] > NW'(whpp_pkg::PRED_MAX)) ? whpp_pkg::PRED_MAX
                                                         : quot_ff[p][whpp_pkg::PRED_W-1:0];
         now_over[p]  = lvl_ff[p] > limit_ff[p];
         pred_over[p] = (quot_ff[p] > NW'(limit_ff[p]))
                        || ((quot_ff[p] == NW'(limit_ff[p])) && (rem_ff[p] != '0));
      end
      rsp_in.zone_out        = zone_ff;
      rsp_in.pred_co2        = pred[0];
      rsp_in.pred_so2        = pred[1];
      rsp_in.pred_no2        = pred[2];
      rsp_in.pred_pm25       = pred[3];
      rsp_in.now_over_count  = 3'(now_over[0]) + 3'(now_over[1])
                               + 3'(now_over[2]) + 3'(now_over[3]);
      rsp_in.pred_over_count = 3'(pred_over[0]) + 3'(pred_over[1])
                               + 3'(pred_over[2]) + 3'(pred_over[3]);
      rsp_in.action_mask     = now_over | pred_over;
      rsp_in.samples_held    = 5'(n_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.rd_last  = (k_ff == n_ff - 1'b1);
   assign status.div_last = (qcnt_ff == QCW'(NW - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   `WHPP_ASSERT_IMPLY(a_rem_below_den, clock, reset, cmd.divide, rem_ff[0] < den_ff)
   `WHPP_ASSERT_IMPLY(a_walk_len, clock, reset, cmd.read, (n_ff != '0) && (n_ff <= CW'(HISTORY_LEN)))
   `WHPP_ASSERT_NEXT(a_read_pipe, clock, reset, cmd.read, rd_v_ff)

endmodule

[src/weighted_history_pollution_predictor.sv]
// ----------------------------------------------------------------------------
// weighted_history_pollution_predictor
// Per-zone pollutant history with a linearly weighted moving-average forecast.
// ----------------------------------------------------------------------------
// Each request transaction carries one sample for a zone. The sample is
// appended to that zone's ring of the last HISTORY_LEN samples (oldest
// dropped once full), then the history is walked oldest to newest with
// weights 1..n, scaled by the wind and humidity factors and divided by the
// weight total. One response transaction follows per request. The walk
// makes one history memory read per cycle over the n samples now held for
// the zone, and the one-bit-a-cycle divider works over a dividend NW bits
// wide (46 at the default sizes).
// A new request is taken once the previous result sits in the output
// register, even while that result still waits for rsp_ready. The limit
// registers are written through the csr_ channel, which is always ready.
// ----------------------------------------------------------------------------
module weighted_history_pollution_predictor #(
   parameter int ZONES       = 8,
   parameter int HISTORY_LEN = 30
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  whpp_pkg::req_type              req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output whpp_pkg::rsp_type              rsp_data,
   // limit register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [whpp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [whpp_pkg::LVL_W-1:0]     csr_data
);

   whpp_pkg::cmd_type    cmd;
   whpp_pkg::status_type status;

   // limit writes never stall
   assign csr_ready = 1'b1;

   // sequence the append, walk, scale and divide steps
   whpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the history rings and do the arithmetic
   whpp_dp #(
      .ZONES       (ZONES),
      .HISTORY_LEN (HISTORY_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
